FILE: design/bpl_pkg.sv
`default_nettype none
package bpl_pkg;

  localparam int SAMPLE_W        = 16;
  localparam int THR_W           = 13;
  localparam int DIV_W           = 15;                 // divisor never exceeds 32767
  localparam int PROD_W          = SAMPLE_W + THR_W;   // |sample| * threshold
  localparam int CNT_W           = 5;                  // counts PROD_W divide steps
  localparam int MAX_SAMPLES_DEF = 64;
  localparam logic [THR_W-1:0] THRESHOLD_RESET = 13'd5000;

  typedef enum logic [2:0] {
    S_FILL,
    S_DECIDE,
    S_READ,
    S_MUL,
    S_DIV,
    S_OUT
  } state_t;

endpackage
`default_nettype wire

FILE: design/bpl_ram.sv
`default_nettype none
module bpl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: design/buffer_peak_limiter.sv
// input: a sample without the end mark is taken in S_FILL; the sample that ends the
// buffer (or fills the store) is followed by S_DECIDE, which picks the divisor
// output: each result word goes through store read, multiply, a 29-step restoring
// divide in one shared subtractor and output hold; a zero divisor skips the divide
// reset: synchronous active-high rst sets threshold to 5000, clears peak, fill and flag
`default_nettype none
module buffer_peak_limiter
  import bpl_pkg::*;
#(
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [THR_W-1:0]           threshold,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic signed [SAMPLE_W-1:0] sample_in,
  input  wire logic                       last_in,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic signed [SAMPLE_W-1:0]      sample_out,
  output logic                            last_out
);

  localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int FW = $clog2(MAX_SAMPLES + 1);
  localparam logic [FW-1:0]    FULL     = FW'(MAX_SAMPLES);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(PROD_W - 1);

  state_t state, state_next;

  logic [THR_W-1:0]           thr;
  logic signed [SAMPLE_W-1:0] peak;
  logic                       over;
  logic [FW-1:0]              fill;
  logic [FW-1:0]              k;
  logic [DIV_W-1:0]           q;
  logic [DIV_W-1:0]           rem;
  logic [PROD_W-1:0]          quo;
  logic [CNT_W-1:0]           cnt;
  logic                       neg;
  logic signed [SAMPLE_W-1:0] res;

  logic                       we;
  logic signed [SAMPLE_W-1:0] rdata;

  logic [FW-1:0]              fill_inc;
  logic [FW-1:0]              k_inc;
  logic                       last_k;
  logic signed [SAMPLE_W-1:0] thr_s;
  logic [SAMPLE_W-1:0]        diff;
  logic [SAMPLE_W-1:0]        half;
  logic [DIV_W-1:0]           q_next;
  logic [SAMPLE_W-1:0]        mag;
  logic [PROD_W-1:0]          prod;
  logic [DIV_W:0]             trial;
  logic                       ge;
  logic [DIV_W:0]             trial_sub;
  logic [DIV_W-1:0]           rem_next;
  logic [PROD_W-1:0]          quo_next;

  bpl_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(MAX_SAMPLES)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(fill[AW-1:0]),
    .wdata(sample_in),
    .raddr(k[AW-1:0]),
    .rdata(rdata)
  );

  assign cfg_ready = 1'b1;
  assign fill_inc  = fill + FW'(1);
  assign k_inc     = k + FW'(1);
  assign last_k    = (k_inc == fill);
  assign thr_s     = $signed({{(SAMPLE_W-THR_W){1'b0}}, thr});

  // halfway point between peak and threshold, rounded toward the peak
  assign diff = $unsigned(peak) - $unsigned(thr_s);
  assign half = $unsigned(peak) - {1'b0, diff[SAMPLE_W-1:1]};

  always_comb begin
    if (over) begin
      q_next = peak[DIV_W-1:0];
    end else if (peak > thr_s) begin
      q_next = half[DIV_W-1:0];
    end else begin
      q_next = DIV_W'(thr);
    end
  end

  // magnitude times threshold, sign applied after the divide
  assign mag  = rdata[SAMPLE_W-1] ? $unsigned(-rdata) : $unsigned(rdata);
  assign prod = PROD_W'(mag) * PROD_W'(thr);

  // one restoring divide step
  assign trial     = {rem, quo[PROD_W-1]};
  assign ge        = (trial >= {1'b0, q});
  assign trial_sub = trial - {1'b0, q};
  assign rem_next  = ge ? trial_sub[DIV_W-1:0] : trial[DIV_W-1:0];
  assign quo_next  = {quo[PROD_W-2:0], ge};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_FILL;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    out_valid  = 1'b0;
    we         = 1'b0;
    unique case (state)
      S_FILL: begin
        in_stall = 1'b0;
        we       = in_valid;
        if (in_valid && (last_in || fill_inc == FULL)) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_next = S_READ;
      end
      S_READ: begin
        state_next = S_MUL;
      end
      S_MUL: begin
        state_next = (q == '0) ? S_OUT : S_DIV;
      end
      S_DIV: begin
        if (cnt == DIV_LAST) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_next = last_k ? S_FILL : S_READ;
        end
      end
      default: begin
        state_next = S_FILL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      thr  <= THRESHOLD_RESET;
      peak <= '0;
      over <= 1'b0;
      fill <= '0;
      k    <= '0;
    end else begin
      if (cfg_valid) begin
        thr <= threshold;
      end
      unique case (state)
        S_FILL: begin
          if (in_valid) begin
            fill <= fill_inc;
            if (sample_in > thr_s) begin
              over <= 1'b1;
              if (sample_in > peak) begin
                peak <= sample_in;
              end
            end
          end
        end
        S_DECIDE: begin
          q    <= q_next;
          over <= 1'b0;
          k    <= '0;
          if (!over) begin
            peak <= thr_s;
          end
        end
        S_READ: begin
        end
        S_MUL: begin
          neg <= rdata[SAMPLE_W-1];
          res <= rdata;
          quo <= prod;
          rem <= '0;
          cnt <= '0;
        end
        S_DIV: begin
          rem <= rem_next;
          quo <= quo_next;
          cnt <= cnt + CNT_W'(1);
          if (cnt == DIV_LAST) begin
            res <= neg ? -$signed(quo_next[SAMPLE_W-1:0]) : $signed(quo_next[SAMPLE_W-1:0]);
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            k <= k_inc;
            if (last_k) begin
              fill <= '0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign sample_out = res;
  assign last_out   = last_k;

`ifndef SYNTH
  // store never overflows while words are taken
  a_fill_room: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> fill < FULL)
    else $error("sample taken with store full");

  // partial remainder stays below the divisor
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> rem < q)
    else $error("divide remainder out of range");

  // the final word of a buffer empties the store
  a_buffer_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && last_out |=> fill == '0 && state == S_FILL)
    else $error("store not emptied after last word");

  // kept peak is never negative
  a_peak_pos: assert property (@(posedge clk) disable iff (rst)
    !peak[SAMPLE_W-1])
    else $error("peak level negative");
`endif

endmodule
`default_nettype wire

FILE: tb/sv/bpl_checker.sv
`timescale 1ns / 1ps
module bpl_checker
  import bpl_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [THR_W-1:0]           threshold,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic signed [SAMPLE_W-1:0] sample_in,
  input  logic                       last_in,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic signed [SAMPLE_W-1:0] sample_out,
  input  logic                       last_out,
  output int                         pending,
  output int                         errors
);

  localparam int DEPTH = MAX_SAMPLES_DEF;

  typedef struct {
    logic signed [SAMPLE_W-1:0] value;
    logic                       is_last;
  } scaled_word_t;

  scaled_word_t               scaled_q[$];
  logic signed [SAMPLE_W-1:0] held[DEPTH];
  logic [THR_W-1:0]           thr;
  int                         peak;
  int                         fill;
  logic                       over;

  task automatic report_mismatch(input string what);
    if (errors < 40) $display("mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  // stores one sample; when the buffer ends or the store is full, picks the divisor and scales the lot
  task automatic absorb_sample(input logic signed [SAMPLE_W-1:0] s, input logic end_mark);
    int     a;
    int     q;
    longint r;
    a = int'(thr);
    if (fill < DEPTH) begin
      held[fill] = s;
      fill++;
    end
    if (int'(s) > a) begin
      if (int'(s) > peak) peak = int'(s);
      over = 1'b1;
    end
    if (!end_mark && fill < DEPTH) return;
    if (over) begin
      q = peak;
    end else if (peak > a) begin
      // release: halfway between the old peak and the threshold
      q = peak - (peak - a) / 2;
      peak = a;
    end else begin
      q = a;
      peak = a;
    end
    for (int k = 0; k < fill; k++) begin
      r = (q > 0) ? (longint'(held[k]) * a) / q : longint'(held[k]);
      scaled_q.push_back('{value: r[SAMPLE_W-1:0], is_last: (k == fill - 1)});
    end
    fill = 0;
    over = 1'b0;
  endtask

  task automatic check_word(input logic signed [SAMPLE_W-1:0] got_s, input logic got_l);
    scaled_word_t w;
    if (scaled_q.size() == 0) begin
      report_mismatch($sformatf("unexpected word sample_out=%0d last_out=%0b", got_s, got_l));
      return;
    end
    w = scaled_q.pop_front();
    if (got_s !== w.value)
      report_mismatch($sformatf("sample_out=%0d, want %0d", got_s, w.value));
    if (got_l !== w.is_last)
      report_mismatch($sformatf("last_out=%0b, want %0b", got_l, w.is_last));
  endtask

  initial begin
    errors  = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      thr  = THRESHOLD_RESET;
      peak = 0;
      fill = 0;
      over = 1'b0;
      scaled_q.delete();
    end else begin
      // results first: a word can never stem from a sample taken at the same edge
      if (out_valid && !out_stall) check_word(sample_out, last_out);
      if (in_valid && !in_stall) absorb_sample(sample_in, last_in);
      if (cfg_valid && cfg_ready) thr = threshold;
    end
    pending = scaled_q.size();
  end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import bpl_pkg::*;

  localparam int RANDOM_ITEMS = 210;
  localparam int HOLD_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 300000;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [THR_W-1:0]           threshold = '0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic signed [SAMPLE_W-1:0] sample_in = '0;
  logic                       last_in = 1'b0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [SAMPLE_W-1:0] sample_out;
  logic                       last_out;

  int pending;
  int fail_count;
  int cycle_count;
  int cur_thr = 5000;
  bit in_gaps = 1'b0;
  bit out_gaps = 1'b0;
  bit hold_request = 1'b0;

  always #10 clk = ~clk;

  buffer_peak_limiter dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .threshold  (threshold),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .sample_in  (sample_in),
    .last_in    (last_in),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .sample_out (sample_out),
    .last_out   (last_out)
  );

  bpl_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .threshold  (threshold),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .sample_in  (sample_in),
    .last_in    (last_in),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .sample_out (sample_out),
    .last_out   (last_out),
    .pending    (pending),
    .errors     (fail_count)
  );

  // valid stays up between back-to-back words; the next call or wait_idle lowers it
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic end_mark);
    @(negedge clk);
    if (in_gaps && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_valid  <= 1'b1;
    sample_in <= s;
    last_in   <= end_mark;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    // divisor pick after the buffer end
    repeat (4) @(negedge clk);
  endtask

  task automatic write_threshold(input int v);
    wait_idle();
    cfg_valid <= 1'b1;
    threshold <= v[THR_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cur_thr = v;
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample(input bit quiet, input int thr);
    int v;
    if (quiet) begin
      v = int'($urandom_range(0, thr + 32768)) - 32768;
    end else begin
      case ($urandom_range(0, 9))
        0: v = 32767;
        1: v = -32768;
        2: v = thr;
        3: v = thr + 1;
        4: v = 0;
        default: v = int'($urandom_range(0, 65535));
      endcase
    end
    return v[SAMPLE_W-1:0];
  endfunction

  function automatic int pick_threshold();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 100;
      2: return 5000;
      3: return 8191;
      4: return int'($urandom_range(0, 8191));
      default: return int'($urandom_range(100, 5000));
    endcase
  endfunction

  task automatic send_buffer(input int len, input bit end_mark);
    bit quiet;
    quiet = ($urandom_range(0, 9) < 4);
    for (int i = 0; i < len; i++)
      send_sample(pick_sample(quiet, cur_thr), end_mark && (i == len - 1));
  endtask

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
      end else if (out_gaps && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 18)) @(negedge clk);
      end
      out_stall <= 1'b0;
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int  sent;
    int  len;
    bit  pressed;
    int  r;
    sent    = 0;
    pressed = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset threshold: loud buffer, then a quiet one to hit the release case
    send_sample(16'sd32767, 1'b0);
    send_sample(-16'sd32768, 1'b0);
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd5000, 1'b0);
    send_sample(16'sd5001, 1'b1);
    send_sample(16'sd100, 1'b0);
    send_sample(-16'sd1, 1'b1);
    send_sample(16'sd4999, 1'b1);
    send_sample(16'sd1, 1'b1);
    // threshold changed with a buffer half filled
    send_sample(-16'sd7, 1'b0);
    send_sample(16'sd3000, 1'b0);
    write_threshold(0);
    send_sample(16'sd2, 1'b1);
    // zero threshold: release from the old peak, then straight pass-through
    send_sample(-16'sd5, 1'b0);
    send_sample(16'sd0, 1'b1);
    send_sample(-16'sd32768, 1'b0);
    send_sample(-16'sd1, 1'b1);
    write_threshold(8191);
    send_sample(16'sd8191, 1'b0);
    send_sample(16'sd8192, 1'b0);
    send_sample(-16'sd32768, 1'b1);
    write_threshold(100);
    send_sample(16'sd101, 1'b0);
    send_sample(16'sd100, 1'b0);
    send_sample(-16'sd100, 1'b1);
    wait_idle();

    in_gaps  = 1'b1;
    out_gaps = 1'b1;
    // full store with no end mark
    send_buffer(64, 1'b0);
    // directed samples plus the full-store buffer
    sent = 22 + 64;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 5) == 0) write_threshold(pick_threshold());
      if (!pressed && sent >= 100) begin
        hold_request = 1'b1;
        pressed      = 1'b1;
      end
      if (sent >= RANDOM_ITEMS - 40) begin
        in_gaps  = 1'b0;
        out_gaps = 1'b0;
      end
      r = $urandom_range(0, 19);
      if (r < 14) len = $urandom_range(1, 10);
      else if (r < 18) len = $urandom_range(11, 40);
      else len = 64;
      if (len > RANDOM_ITEMS - sent) len = RANDOM_ITEMS - sent;
      send_buffer(len, (len < 64) || $urandom_range(0, 1) == 1);
      sent += len;
    end

    wait_idle();
    repeat (60) @(negedge clk);
    if (fail_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

FILE: files.f
design/bpl_pkg.sv
design/bpl_ram.sv
design/buffer_peak_limiter.sv
tb/sv/bpl_checker.sv
tb/sv/tb_top.sv
